// File: src/rlew_pkg.sv
package rlew_pkg;

    // default size of the destination plane in words
    localparam int PLANE_WORDS_DEF = 4096;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // fixed field widths
    localparam int WORD_W  = 16;
    localparam int LIMIT_W = 13;
    localparam int START_W = 12;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAG_WORD    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_LIMIT = 1'd1;

    // configuration reset values
    localparam logic [WORD_W-1:0]  TAG_WORD_RST    = 16'hABCD;
    localparam logic [LIMIT_W-1:0] PLANE_LIMIT_RST = 13'd4096;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CLIPPED = 2'd1,
        ST_ERROR   = 2'd2
    } status_t;

    // work items handed from the front to the back
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_ERROR = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] count;
    } cmd_t;

endpackage

// File: src/rlew_tagged_run_decoder.sv
// channel   direction  handshake            payload
// in        input      in_valid/in_stall    word, last_word
// out       output     out_valid/out_stall  run_value, run_count, start_index, status
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one word is taken every cycle while the queue has room; a result goes through the
// command queue entry, then the output register in the back end.
// reset: header expected, write position zero, queue empty, tag 0xABCD, limit 4096.
// out_stall holds the output register; the four-entry queue absorbs commands
// meanwhile and in_stall rises only once it is full. cfg_ready is always high.
module rlew_tagged_run_decoder
#(
    parameter int PLANE_WORDS = rlew_pkg::PLANE_WORDS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [rlew_pkg::WORD_W-1:0]      word,
    input  logic                             last_word,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [rlew_pkg::WORD_W-1:0]      run_value,
    output logic [rlew_pkg::WORD_W-1:0]      run_count,
    output logic [rlew_pkg::START_W-1:0]     start_index,
    output logic [1:0]                       status,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rlew_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rlew_pkg::WORD_W-1:0]      cfg_data
);

    logic [rlew_pkg::WORD_W-1:0]  tag_word_reg;
    logic [rlew_pkg::LIMIT_W-1:0] plane_limit_reg;
    logic                         cmd_push;
    rlew_pkg::cmd_t               push_cmd;
    logic                         q_full;
    logic                         q_valid;
    logic                         q_pop;
    rlew_pkg::cmd_t               q_cmd;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_word_reg    <= rlew_pkg::TAG_WORD_RST;
            plane_limit_reg <= rlew_pkg::PLANE_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rlew_pkg::CFG_TAG_WORD:    tag_word_reg    <= cfg_data;
                rlew_pkg::CFG_PLANE_LIMIT: plane_limit_reg <= cfg_data[rlew_pkg::LIMIT_W-1:0];
                default:                   tag_word_reg    <= tag_word_reg;
            endcase
        end
    end

    // word classification
    rlew_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .q_full    (q_full),
        .word      (word),
        .last_word (last_word),
        .tag_word  (tag_word_reg),
        .in_stall  (in_stall),
        .cmd_push  (cmd_push),
        .cmd       (push_cmd)
    );

    // decoupling queue
    rlew_cmd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (q_cmd)
    );

    // run execution and clipping
    rlew_back #(
        .PLANE_WORDS (PLANE_WORDS)
    ) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (q_valid),
        .cmd         (q_cmd),
        .cmd_pop     (q_pop),
        .plane_limit (plane_limit_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .run_value   (run_value),
        .run_count   (run_count),
        .start_index (start_index),
        .status      (status)
    );

endmodule

// File: src/rlew_front.sv
module rlew_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       q_full,
    input  logic [rlew_pkg::WORD_W-1:0] word,
    input  logic                       last_word,
    input  logic [rlew_pkg::WORD_W-1:0] tag_word,
    output logic                       in_stall,
    output logic                       cmd_push,
    output rlew_pkg::cmd_t             cmd
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_DATA,
        PH_COUNT,
        PH_VALUE
    } phase_t;

    phase_t                      phase_reg;
    phase_t                      phase_next;
    logic [rlew_pkg::WORD_W-1:0] held_count_reg;
    logic [rlew_pkg::WORD_W-1:0] held_count_next;
    logic                        fire;

    // words are taken whenever the queue has room
    assign in_stall = q_full;
    assign fire     = in_valid && !q_full;

    // classify the word and build the command for the back end
    always_comb
    begin
        phase_next      = phase_reg;
        held_count_next = held_count_reg;
        cmd_push        = 1'b0;
        cmd.kind        = rlew_pkg::CMD_RUN;
        cmd.value       = word;
        cmd.count       = rlew_pkg::WORD_W'(1);
        if (fire)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    cmd_push   = 1'b1;
                    cmd.kind   = rlew_pkg::CMD_CLEAR;
                    phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    if (word != tag_word)
                    begin
                        cmd_push = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_COUNT;
                        cmd_push   = last_word;
                        cmd.kind   = rlew_pkg::CMD_ERROR;
                    end
                end
                PH_COUNT:
                begin
                    held_count_next = word;
                    phase_next      = PH_VALUE;
                    cmd_push        = last_word;
                    cmd.kind        = rlew_pkg::CMD_ERROR;
                end
                PH_VALUE:
                begin
                    cmd_push   = (held_count_reg != '0);
                    cmd.count  = held_count_reg;
                    phase_next = PH_DATA;
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
            // a block end always returns to the header
            if (last_word)
            begin
                phase_next = PH_HEADER;
            end
        end
    end

    // phase and pending count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            held_count_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            held_count_reg <= held_count_next;
        end
    end

endmodule

// File: src/rlew_cmd_queue.sv
module rlew_cmd_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rlew_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           pop_valid,
    output rlew_pkg::cmd_t pop_cmd
);

    localparam int Depth = rlew_pkg::QUEUE_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    rlew_pkg::cmd_t  mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] cnt_reg;
    logic [CntW-1:0] cnt_next;
    logic            do_push;
    logic            do_pop;

    assign full      = (cnt_reg == CntW'(Depth));
    assign pop_valid = (cnt_reg != '0);
    assign pop_cmd   = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // pointer and fill count updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CntW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: src/rlew_back.sv
module rlew_back
#(
    parameter int PLANE_WORDS = rlew_pkg::PLANE_WORDS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    input  rlew_pkg::cmd_t               cmd,
    output logic                         cmd_pop,
    input  logic [rlew_pkg::LIMIT_W-1:0] plane_limit,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [rlew_pkg::WORD_W-1:0]  run_value,
    output logic [rlew_pkg::WORD_W-1:0]  run_count,
    output logic [rlew_pkg::START_W-1:0] start_index,
    output logic [1:0]                   status
);

    localparam int PosW = $clog2(PLANE_WORDS + 1);
    localparam int LimW = (PosW > rlew_pkg::LIMIT_W) ? PosW : rlew_pkg::LIMIT_W;
    localparam int CmpW = (LimW > rlew_pkg::WORD_W) ? LimW : rlew_pkg::WORD_W;

    logic [PosW-1:0]              pos_reg;
    logic [PosW-1:0]              pos_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [rlew_pkg::WORD_W-1:0]  run_value_reg;
    logic [rlew_pkg::WORD_W-1:0]  run_value_next;
    logic [rlew_pkg::WORD_W-1:0]  run_count_reg;
    logic [rlew_pkg::WORD_W-1:0]  run_count_next;
    logic [rlew_pkg::START_W-1:0] start_index_reg;
    logic [rlew_pkg::START_W-1:0] start_index_next;
    rlew_pkg::status_t            status_reg;
    rlew_pkg::status_t            status_next;
    logic                         load;
    logic [LimW-1:0]              limit_ext;
    logic [LimW-1:0]              lim;
    logic [LimW-1:0]              pos_lim;
    logic [LimW-1:0]              room;
    logic [CmpW-1:0]              room_wide;
    logic [CmpW-1:0]              req_wide;
    logic [CmpW-1:0]              used_wide;
    logic [CmpW-1:0]              pos_wide;
    logic                         clip;

    // output register frees up when empty or being taken
    assign load    = !out_valid_reg || !out_stall;
    assign cmd_pop = cmd_valid && load;

    // active limit and room left in the plane
    assign limit_ext = LimW'(plane_limit);
    assign lim       = (limit_ext > LimW'(PLANE_WORDS)) ? LimW'(PLANE_WORDS) : limit_ext;
    assign pos_lim   = LimW'(pos_reg);
    assign room      = (pos_lim < lim) ? (lim - pos_lim) : '0;
    assign room_wide = CmpW'(room);
    assign req_wide  = CmpW'(cmd.count);
    assign clip      = (req_wide > room_wide);
    assign used_wide = clip ? room_wide : req_wide;
    assign pos_wide  = CmpW'(pos_reg);

    // carry out one command
    always_comb
    begin
        pos_next         = pos_reg;
        out_valid_next   = out_valid_reg && out_stall;
        run_value_next   = run_value_reg;
        run_count_next   = run_count_reg;
        start_index_next = start_index_reg;
        status_next      = status_reg;
        if (cmd_pop)
        begin
            case (cmd.kind)
                rlew_pkg::CMD_CLEAR:
                begin
                    pos_next = '0;
                end
                rlew_pkg::CMD_RUN:
                begin
                    pos_next         = pos_reg + PosW'(used_wide);
                    out_valid_next   = 1'b1;
                    run_value_next   = cmd.value;
                    run_count_next   = used_wide[rlew_pkg::WORD_W-1:0];
                    start_index_next = pos_wide[rlew_pkg::START_W-1:0];
                    status_next      = clip ? rlew_pkg::ST_CLIPPED : rlew_pkg::ST_OK;
                end
                rlew_pkg::CMD_ERROR:
                begin
                    out_valid_next   = 1'b1;
                    run_value_next   = '0;
                    run_count_next   = '0;
                    start_index_next = pos_wide[rlew_pkg::START_W-1:0];
                    status_next      = rlew_pkg::ST_ERROR;
                end
                default:
                begin
                    pos_next = pos_reg;
                end
            endcase
        end
    end

    // position and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        run_value_reg   <= run_value_next;
        run_count_reg   <= run_count_next;
        start_index_reg <= start_index_next;
        status_reg      <= status_next;
    end

    assign out_valid   = out_valid_reg;
    assign run_value   = run_value_reg;
    assign run_count   = run_count_reg;
    assign start_index = start_index_reg;
    assign status      = status_reg;

endmodule

// File: tb/sv/rlew_tagged_run_decoder_test.sv
`timescale 1ns / 1ps

module rlew_tagged_run_decoder_test;

    // one decoded run as seen on the output channel
    typedef struct packed {
        logic [rlew_pkg::WORD_W-1:0]  value;
        logic [rlew_pkg::WORD_W-1:0]  count;
        logic [rlew_pkg::START_W-1:0] start;
        rlew_pkg::status_t            code;
    } run_t;

    typedef enum logic [1:0] {
        EXPECT_HEADER = 2'd0,
        IN_DATA       = 2'd1,
        EXPECT_COUNT  = 2'd2,
        EXPECT_VALUE  = 2'd3
    } decode_phase_t;

    // decoder state mirror and queue of runs still to arrive
    class run_scoreboard;
        logic [rlew_pkg::WORD_W-1:0]  tag_word;
        logic [rlew_pkg::LIMIT_W-1:0] plane_limit;
        decode_phase_t                phase;
        logic [rlew_pkg::WORD_W-1:0]  held_count;
        int unsigned                  write_pos;
        run_t                         pending_runs[$];
        int                           errors;

        function new();
            tag_word    = rlew_pkg::TAG_WORD_RST;
            plane_limit = rlew_pkg::PLANE_LIMIT_RST;
            phase       = EXPECT_HEADER;
            held_count  = '0;
            write_pos   = 0;
            errors      = 0;
        endfunction

        function void write_reg(logic [rlew_pkg::CFG_INDEX_W-1:0] idx,
                                logic [rlew_pkg::WORD_W-1:0] data);
            if (idx == rlew_pkg::CFG_TAG_WORD)
                tag_word = data;
            else if (idx == rlew_pkg::CFG_PLANE_LIMIT)
                plane_limit = data[rlew_pkg::LIMIT_W-1:0];
        endfunction

        // run of count copies, clipped at the room left in the plane
        function void push_run(logic [rlew_pkg::WORD_W-1:0] value, int unsigned count);
            int unsigned lim;
            int unsigned room;
            run_t r;
            lim = (plane_limit > rlew_pkg::PLANE_WORDS_DEF) ?
                  rlew_pkg::PLANE_WORDS_DEF : plane_limit;
            room = (write_pos < lim) ? lim - write_pos : 0;
            r.value = value;
            r.start = rlew_pkg::START_W'(write_pos);
            r.code = rlew_pkg::ST_OK;
            if (count > room)
            begin
                count = room;
                r.code = rlew_pkg::ST_CLIPPED;
            end
            r.count = rlew_pkg::WORD_W'(count);
            write_pos = write_pos + count;
            pending_runs.push_back(r);
        endfunction

        // block ended inside a tag triple
        function void push_broken_triple();
            run_t r;
            r.value = '0;
            r.count = '0;
            r.start = rlew_pkg::START_W'(write_pos);
            r.code = rlew_pkg::ST_ERROR;
            pending_runs.push_back(r);
        endfunction

        // accepted input transaction
        function void decode_word(logic [rlew_pkg::WORD_W-1:0] w, logic last);
            case (phase)
                EXPECT_HEADER:
                begin
                    write_pos = 0;
                    phase = IN_DATA;
                end
                IN_DATA:
                begin
                    if (w != tag_word)
                        push_run(w, 1);
                    else
                    begin
                        phase = EXPECT_COUNT;
                        if (last)
                            push_broken_triple();
                    end
                end
                EXPECT_COUNT:
                begin
                    held_count = w;
                    phase = EXPECT_VALUE;
                    if (last)
                        push_broken_triple();
                end
                default:
                begin
                    if (held_count != 0)
                        push_run(w, held_count);
                    phase = IN_DATA;
                end
            endcase
            if (last)
                phase = EXPECT_HEADER;
        endfunction

        // accepted output transaction against the oldest expected run
        function void check_run(run_t got);
            run_t want;
            if (pending_runs.size() == 0)
            begin
                $error("unexpected run: value %h count %0d start %0d code %0d",
                       got.value, got.count, got.start, got.code);
                errors++;
                return;
            end
            want = pending_runs.pop_front();
            if (got.value !== want.value)
            begin
                $error("run_value: expected %h, got %h", want.value, got.value);
                errors++;
            end
            if (got.count !== want.count)
            begin
                $error("run_count: expected %0d, got %0d", want.count, got.count);
                errors++;
            end
            if (got.start !== want.start)
            begin
                $error("start_index: expected %0d, got %0d", want.start, got.start);
                errors++;
            end
            if (got.code !== want.code)
            begin
                $error("status: expected %0d, got %0d", want.code, got.code);
                errors++;
            end
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic [rlew_pkg::WORD_W-1:0]      word;
    logic                             last_word;
    logic                             out_valid;
    logic                             out_stall;
    logic [rlew_pkg::WORD_W-1:0]      run_value;
    logic [rlew_pkg::WORD_W-1:0]      run_count;
    logic [rlew_pkg::START_W-1:0]     start_index;
    logic [1:0]                       status;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [rlew_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [rlew_pkg::WORD_W-1:0]      cfg_data;

    run_scoreboard sb = new();

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_off_cycles = 0;
    int words_accepted  = 0;

    rlew_tagged_run_decoder u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .word       (word),
        .last_word  (last_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .run_value  (run_value),
        .run_count  (run_count),
        .start_index(start_index),
        .status     (status),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // clock
    always #5 clk = ~clk;

    // offer one word, after a random idle gap, and wait for its transaction
    task automatic send_word(input logic [rlew_pkg::WORD_W-1:0] w, input logic last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 20)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        word      <= w;
        last_word <= last;
        do @(posedge clk); while (in_stall);
        sb.decode_word(w, last);
        words_accepted++;
    endtask

    // both registers, back to back on the config channel
    task automatic apply_settings(input logic [rlew_pkg::WORD_W-1:0] tag,
                                  input logic [rlew_pkg::LIMIT_W-1:0] lim);
        cfg_valid <= 1'b1;
        cfg_index <= rlew_pkg::CFG_TAG_WORD;
        cfg_data  <= tag;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(rlew_pkg::CFG_TAG_WORD, tag);
        cfg_index <= rlew_pkg::CFG_PLANE_LIMIT;
        cfg_data  <= rlew_pkg::WORD_W'(lim);
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(rlew_pkg::CFG_PLANE_LIMIT, rlew_pkg::WORD_W'(lim));
        cfg_valid <= 1'b0;
    endtask

    // stop offering and let every expected run come out
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_runs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [rlew_pkg::WORD_W-1:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return '0;
        if (r < 65)
            return rlew_pkg::WORD_W'($urandom_range(1, 4));
        if (r < 90)
            return rlew_pkg::WORD_W'($urandom_range(5, 64));
        return rlew_pkg::WORD_W'($urandom);
    endfunction

    // one block: mostly well formed, some noise, some cut inside a triple
    task automatic send_block();
        int roll;
        int elems;
        logic [rlew_pkg::WORD_W-1:0] lit;
        logic [rlew_pkg::WORD_W-1:0] cnt;
        roll = $urandom_range(99);
        if (roll < 8)
        begin
            elems = $urandom_range(1, 10);
            for (int i = 0; i < elems; i++)
                send_word(rlew_pkg::WORD_W'($urandom),
                          (i == elems - 1) || ($urandom_range(7) == 0));
            return;
        end
        if (roll < 12)
        begin
            send_word(rlew_pkg::WORD_W'($urandom), 1'b1);
            return;
        end
        send_word(rlew_pkg::WORD_W'($urandom), 1'b0);
        elems = $urandom_range(1, 16);
        for (int i = 0; i < elems; i++)
        begin
            logic fin;
            fin = (i == elems - 1);
            cnt = pick_count();
            if (fin && roll >= 88)
            begin
                // cut on the tag or on the count word
                if ($urandom_range(1) == 0)
                    send_word(sb.tag_word, 1'b1);
                else
                begin
                    send_word(sb.tag_word, 1'b0);
                    send_word(cnt, 1'b1);
                end
            end
            else if ($urandom_range(9) < 7)
            begin
                lit = rlew_pkg::WORD_W'($urandom);
                if (lit == sb.tag_word)
                    lit = ~lit;
                send_word(lit, fin);
            end
            else
            begin
                send_word(sb.tag_word, 1'b0);
                send_word(cnt, 1'b0);
                send_word(rlew_pkg::WORD_W'($urandom), fin);
            end
        end
    endtask

    // output side: check accepted runs, drive stall
    initial
    begin : receiver
        run_t got;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.value = run_value;
                got.count = run_count;
                got.start = start_index;
                got.code  = rlew_pkg::status_t'(status);
                sb.check_run(got);
            end
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        logic [rlew_pkg::LIMIT_W-1:0] lim;
        logic [rlew_pkg::WORD_W-1:0]  tag;
        int target;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        word      <= '0;
        last_word <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= rlew_pkg::CFG_TAG_WORD;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_settings(rlew_pkg::TAG_WORD_RST, rlew_pkg::PLANE_LIMIT_RST);

        // literals at both extremes, a run, a zero-count triple
        send_word(16'h0123, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(rlew_pkg::TAG_WORD_RST, 1'b0);
        send_word(16'd3, 1'b0);
        send_word(16'h1234, 1'b0);
        send_word(rlew_pkg::TAG_WORD_RST, 1'b0);
        send_word(16'd0, 1'b0);
        send_word(16'h5555, 1'b0);
        send_word(16'h0001, 1'b1);
        // block ends on the tag word
        send_word(16'hFFFF, 1'b0);
        send_word(rlew_pkg::TAG_WORD_RST, 1'b1);
        // block ends on the count word
        send_word(16'h0000, 1'b0);
        send_word(rlew_pkg::TAG_WORD_RST, 1'b0);
        send_word(16'd5, 1'b1);
        // header only
        send_word(16'h8000, 1'b1);
        // run clipped at the plane limit, then a literal with no room left
        send_word(16'h0000, 1'b0);
        send_word(rlew_pkg::TAG_WORD_RST, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'hAAAA, 1'b0);
        send_word(16'h7777, 1'b0);
        send_word(16'h8888, 1'b1);
        drain();

        // random phases, each with its own settings and idle pattern
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: begin tag = 16'h0000; lim = 13'd37; end
                1: begin tag = 16'hFFFF; lim = 13'd0; end
                2: begin tag = rlew_pkg::WORD_W'($urandom); lim = 13'd1; end
                3: begin tag = rlew_pkg::TAG_WORD_RST; lim = 13'h1FFF; end
                4: begin tag = rlew_pkg::WORD_W'($urandom); lim = rlew_pkg::PLANE_LIMIT_RST; end
                default:
                begin
                    tag = rlew_pkg::WORD_W'($urandom);
                    lim = rlew_pkg::LIMIT_W'($urandom_range(2, 300));
                end
            endcase
            apply_settings(tag, lim);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase

            if (p == 0)
            begin
                // long receiver hold-off while literals keep coming
                hold_off_cycles = 80;
                send_word(16'h0042, 1'b0);
                for (int i = 0; i < 40; i++)
                    send_word(16'h1000 + rlew_pkg::WORD_W'(i), i == 39);
            end

            target = words_accepted + 150;
            while (words_accepted < target)
                send_block();
            drain();
        end

        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
